[design/cbe_pkg.sv]
// Shared types for the cubic Bezier evaluator: the result source code and the
// control bundle that the top level hands to each per-axis blend datapath.
// No dependencies.
package cbe_pkg;

    // Source of a result: the blended curve, or a control point passed through
    typedef enum logic [1:0] {
        PICK_CURVE,
        PICK_START,
        PICK_END
    } pick_t;

    // Stage enables and result source for the back half of the pipeline
    typedef struct packed {
        logic  en_prod;
        logic  en_sum;
        logic  en_out;
        pick_t pick;
    } blend_ctrl_t;

endpackage

[design/cubic_bezier_eval_3d.sv]
// Cubic Bezier evaluator, 3D: B(t) from four Q8.8 control points per input t.
// Throughput: one transaction per cycle unless the output stalls; six register
//   stages, each holding about one multiply or one wide add/compare, with a
//   valid bit per stage.
// Reset (aresetn low, synchronous): pipeline emptied, control points cleared.
// Depends on cbe_pkg and cbe_axis_blend.
module cubic_bezier_eval_3d #(
    parameter int COORD_WIDTH     = 16,
    parameter int PARAM_FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Parameter stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((PARAM_FRAC_BITS + 9) / 8) * 8 - 1:0] s_tdata, // curve_param

    // Curve point stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata, // out_x, out_y, out_z

    // Control point registers, 8 bytes apart
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int F      = PARAM_FRAC_BITS;
    localparam int CW     = COORD_WIDTH;
    localparam int PW     = F + 2;          // input parameter width
    localparam int WW     = F + 1;          // unsigned weight width, holds 1.0
    localparam int MW     = ((3 * CW + 7) / 8) * 8;
    localparam int NSTAGE = 6;

    localparam logic [WW-1:0] FIX_ONE = {1'b1, {F{1'b0}}};
    localparam logic [2*WW-1:0] HALF_P =
        {{(2 * WW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [2*WW+1:0] HALF_Q =
        {{(2 * WW + 2 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

    // ------------------------------------------------------------------
    // Control point registers. Each packs z, y, x from the top down.
    // ------------------------------------------------------------------
    logic [3*CW-1:0] point_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                point_reg[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            point_reg[paddr[4:3]] <= pwdata[3*CW-1:0];
        end
    end

    assign prdata = 64'(point_reg[paddr[4:3]]);
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Flow control. Each stage advances when it is empty or the stage after
    // it advances, so bubbles collapse and a stall holds every item in place.
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_en;

    always_comb begin
        stage_en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

    // ------------------------------------------------------------------
    // Stage 0: classify t and form u = 1 - t. Outside [0, 1] the result
    // passes a control point through and the weights are don't-care.
    // ------------------------------------------------------------------
    logic [PW-1:0]       t_in;
    logic [WW-1:0]       t_mag;
    cbe_pkg::pick_t      pick_next;
    logic [WW-1:0]       t0_reg, u0_reg;
    cbe_pkg::pick_t      pick_reg [5];

    assign t_in  = s_tdata[PW-1:0];
    assign t_mag = t_in[PW-2:0];

    always_comb begin
        if (t_in[PW-1]) begin
            pick_next = cbe_pkg::PICK_START;
        end else if (t_mag > FIX_ONE) begin
            pick_next = cbe_pkg::PICK_END;
        end else begin
            pick_next = cbe_pkg::PICK_CURVE;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t0_reg      <= t_mag;
            u0_reg      <= FIX_ONE - t_mag;
            pick_reg[0] <= pick_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares u^2 and t^2, rounded back to F fraction bits.
    // ------------------------------------------------------------------
    logic [2*WW-1:0] uu_rnd, tt_rnd;
    logic [WW-1:0]   t1_reg, u1_reg, u2_reg, t2_reg;

    assign uu_rnd = u0_reg * u0_reg + HALF_P;
    assign tt_rnd = t0_reg * t0_reg + HALF_P;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            t1_reg      <= t0_reg;
            u1_reg      <= u0_reg;
            u2_reg      <= uu_rnd[F +: WW];
            t2_reg      <= tt_rnd[F +: WW];
            pick_reg[1] <= pick_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four Bernstein weights, each rounded. All stay <= 1.0.
    // ------------------------------------------------------------------
    logic [WW+1:0]        u2_x3, t2_x3;
    logic [2*WW+1:0]      w0_rnd, w1_rnd, w2_rnd, w3_rnd;
    logic [3:0][WW-1:0]   weight_reg;

    assign u2_x3  = {1'b0, u2_reg, 1'b0} + (WW + 2)'(u2_reg);
    assign t2_x3  = {1'b0, t2_reg, 1'b0} + (WW + 2)'(t2_reg);
    assign w0_rnd = (2 * WW + 2)'(u2_reg * u1_reg) + HALF_Q;
    assign w1_rnd = u2_x3 * t1_reg + HALF_Q;
    assign w2_rnd = t2_x3 * u1_reg + HALF_Q;
    assign w3_rnd = (2 * WW + 2)'(t2_reg * t1_reg) + HALF_Q;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            weight_reg[0] <= w0_rnd[F +: WW];
            weight_reg[1] <= w1_rnd[F +: WW];
            weight_reg[2] <= w2_rnd[F +: WW];
            weight_reg[3] <= w3_rnd[F +: WW];
            pick_reg[2]   <= pick_reg[1];
        end
    end

    // Carry the result source alongside the products and sums
    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            pick_reg[3] <= pick_reg[2];
        end
        if (stage_en[4]) begin
            pick_reg[4] <= pick_reg[3];
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: one blend datapath per axis (products, sum, round and
    // saturate into the output register).
    // ------------------------------------------------------------------
    cbe_pkg::blend_ctrl_t       blend_ctrl;
    logic [2:0][3:0][CW-1:0]    axis_coord;
    logic [2:0][CW-1:0]         axis_out;

    assign blend_ctrl.en_prod = stage_en[3];
    assign blend_ctrl.en_sum  = stage_en[4];
    assign blend_ctrl.en_out  = stage_en[5];
    assign blend_ctrl.pick    = pick_reg[4];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        for (genvar k = 0; k < 4; k++) begin : g_pt
            assign axis_coord[a][k] = point_reg[k][a*CW +: CW];
        end

        cbe_axis_blend #(
            .COORD_WIDTH     (COORD_WIDTH),
            .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
        ) u_blend (
            .aclk      (aclk),
            .ctrl      (blend_ctrl),
            .weight    (weight_reg),
            .coord     (axis_coord[a]),
            .coord_out (axis_out[a])
        );
    end

    // x in the lowest bits, zero fill to whole bytes
    assign m_tdata = MW'(axis_out);

endmodule

[design/cbe_axis_blend.sv]
// One coordinate axis of the Bezier evaluator: weight products, sum, round,
// saturate and pass-through select, as three register stages.
// Depends on cbe_pkg (pick_t, blend_ctrl_t).
module cbe_axis_blend #(
    parameter int COORD_WIDTH     = 16,
    parameter int PARAM_FRAC_BITS = 15
) (
    input  logic                                 aclk,
    input  cbe_pkg::blend_ctrl_t                 ctrl,
    input  logic [3:0][PARAM_FRAC_BITS:0]        weight,
    input  logic [3:0][COORD_WIDTH-1:0]          coord,
    output logic [COORD_WIDTH-1:0]               coord_out
);

    localparam int WW    = PARAM_FRAC_BITS + 1;
    localparam int PRODW = WW + 1 + COORD_WIDTH;
    localparam int SUMW  = WW + COORD_WIDTH + 3;
    localparam int RW    = SUMW - PARAM_FRAC_BITS;

    localparam logic [SUMW-1:0] RND_HALF =
        {{(SUMW - PARAM_FRAC_BITS){1'b0}}, 1'b1, {(PARAM_FRAC_BITS - 1){1'b0}}};
    localparam logic [RW-1:0] SAT_MAX =
        {{(RW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic [RW-1:0] SAT_MIN =
        {{(RW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

    logic signed [PRODW-1:0]      prod_reg [4];
    logic signed [SUMW-1:0]       sum_reg;
    logic signed [SUMW-1:0]       rnd_sum;
    logic signed [RW-1:0]         rnd_q;
    logic [COORD_WIDTH-1:0]       sat_val;
    logic [COORD_WIDTH-1:0]       coord_next;
    logic [COORD_WIDTH-1:0]       coord_out_reg;

    // Weighted coordinates, weights taken as nonnegative
    always_ff @(posedge aclk) begin
        if (ctrl.en_prod) begin
            for (int k = 0; k < 4; k++) begin
                prod_reg[k] <= PRODW'($signed({1'b0, weight[k]}) * $signed(coord[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_sum) begin
            sum_reg <= SUMW'(prod_reg[0]) + SUMW'(prod_reg[1])
                     + SUMW'(prod_reg[2]) + SUMW'(prod_reg[3]);
        end
    end

    // Round half up: add half an LSB, then keep the floor of the shift
    always_comb begin
        rnd_sum = sum_reg + $signed(RND_HALF);
        rnd_q   = rnd_sum[SUMW-1:PARAM_FRAC_BITS];
        if (rnd_q > $signed(SAT_MAX)) begin
            sat_val = SAT_MAX[COORD_WIDTH-1:0];
        end else if (rnd_q < $signed(SAT_MIN)) begin
            sat_val = SAT_MIN[COORD_WIDTH-1:0];
        end else begin
            sat_val = rnd_q[COORD_WIDTH-1:0];
        end

        case (ctrl.pick)
            cbe_pkg::PICK_START: coord_next = coord[0];
            cbe_pkg::PICK_END:   coord_next = coord[3];
            default:             coord_next = sat_val;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_out) begin
            coord_out_reg <= coord_next;
        end
    end

    assign coord_out = coord_out_reg;

endmodule

[verif/cbe_curve_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for cubic_bezier_eval_3d: tracks control point writes on the APB port,
// predicts one curve point per accepted parameter transaction and compares the results in order.
// Standalone; no package needed.
module cbe_curve_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,   // curve_param[16:0], zero fill
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,   // out_x[15:0], out_y[31:16], out_z[47:32]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output int unsigned       errors,
    output int unsigned       pending
);

    localparam int     FRAC      = 15;
    localparam longint FIX_ONE   = 64'sd1 << FRAC;
    localparam longint FIX_HALF  = 64'sd1 << (FRAC - 1);
    localparam longint COORD_MAX = 32767;
    localparam longint COORD_MIN = -32768;
    localparam int     START_PT  = 0;
    localparam int     END_PT    = 3;
    localparam int     MAX_LINES = 40;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } curve_pt_t;

    logic [47:0] ctrl_pt [4];
    curve_pt_t   curve_q [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
        return (a * b + longint'(FIX_HALF)) >> FRAC;
    endfunction

    function automatic curve_pt_t eval_curve(logic signed [16:0] t);
        curve_pt_t      pt;
        longint unsigned tu, u, u2, t2;
        longint          w [4];
        longint          acc, c, r;
        logic [47:0]     p;
        if (t < 0 || longint'(t) > FIX_ONE) begin
            // outside the unit interval: pass the end point through untouched
            p = (t < 0) ? ctrl_pt[START_PT] : ctrl_pt[END_PT];
            pt = p;
            return pt;
        end
        tu   = longint'(t);
        u    = FIX_ONE - tu;
        u2   = fix_mul(u, u);
        t2   = fix_mul(tu, tu);
        w[0] = longint'(fix_mul(u2, u));
        w[1] = longint'(fix_mul(3 * u2, tu));
        w[2] = longint'(fix_mul(3 * t2, u));
        w[3] = longint'(fix_mul(t2, tu));
        for (int ax = 0; ax < 3; ax++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                c   = $signed(ctrl_pt[k][16*ax +: 16]);
                acc = acc + w[k] * c;
            end
            // round half up, then clamp to the Q8.8 range
            r = (acc + FIX_HALF) >>> FRAC;
            if (r > COORD_MAX)
                r = COORD_MAX;
            else if (r < COORD_MIN)
                r = COORD_MIN;
            case (ax)
                0: pt.x = r[15:0];
                1: pt.y = r[15:0];
                default: pt.z = r[15:0];
            endcase
        end
        return pt;
    endfunction

    task automatic report(string msg);
        if (errors < MAX_LINES)
            $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        curve_pt_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++)
                ctrl_pt[i] <= '0;
            curve_q.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready)
                ctrl_pt[paddr[4:3]] <= pwdata[47:0];
            if (s_tvalid && s_tready)
                curve_q.push_back(eval_curve(s_tdata[16:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (curve_q.size() == 0) begin
                    report($sformatf("result %h with nothing outstanding", m_tdata));
                end else begin
                    want = curve_q.pop_front();
                    if (got.x !== want.x)
                        report($sformatf("out_x got %h want %h", got.x, want.x));
                    if (got.y !== want.y)
                        report($sformatf("out_y got %h want %h", got.y, want.y));
                    if (got.z !== want.z)
                        report($sformatf("out_z got %h want %h", got.z, want.z));
                end
            end
            pending <= curve_q.size();
        end
    end

endmodule

[verif/cubic_bezier_eval_3d_tb.sv]
`timescale 1ns / 100ps
// Top of the cubic_bezier_eval_3d testbench: clock, reset, APB control point loads,
// parameter stimulus and result back-pressure. Needs the design and cbe_curve_checker.
module cubic_bezier_eval_3d_tb;

    // Control point register addresses, 8 bytes apart
    typedef enum logic [4:0] {
        ADDR_START        = 5'd0,
        ADDR_START_HANDLE = 5'd8,
        ADDR_END_HANDLE   = 5'd16,
        ADDR_END          = 5'd24
    } pt_addr_t;

    localparam int          LIMIT    = 200000;  // watchdog limit, counted in clock cycles
    localparam int          PHASES   = 6;
    localparam int          PER_PHASE = 220;
    localparam logic [16:0] T_ONE    = 17'd32768;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // curve_param[16:0], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;          // out_x[15:0], out_y[31:16], out_z[47:32]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;

    int unsigned errors, pending;
    int unsigned cycles   = 0;
    int          rdy_hold = 0;
    logic        rdy_bursts  = 1'b1;  // result side stalls enabled
    logic        send_bursts = 1'b1;  // parameter side gaps enabled
    logic        quiet       = 1'b0;  // final stretch: no idling at all

    always #5 aclk = ~aclk;

    cubic_bezier_eval_3d dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cbe_curve_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .errors   (errors),
        .pending  (pending)
    );

    // Watchdog: end the run if the pipeline hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: stall in random bursts, with stretches of no stalls;
    // flip between the two modes now and then
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0)
            rdy_bursts <= ~rdy_bursts;
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && rdy_bursts && $urandom_range(0, 7) == 0) begin
            rdy_hold <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [47:0] pack_pt(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    // style 0: any value, 1: half range extremes, 0, +1 or -1, half any value, 2: small magnitudes
    function automatic logic [15:0] rand_coord(int style);
        logic [15:0] picks [5];
        picks = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
        case (style)
            1: begin
                if ($urandom_range(0, 1) == 0)
                    return picks[$urandom_range(0, 4)];
                return 16'($urandom());
            end
            2: return 16'($urandom_range(0, 2047)) - 16'd1024;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [47:0] rand_point(int style);
        return pack_pt(rand_coord(style), rand_coord(style), rand_coord(style));
    endfunction

    // Mostly inside [0, 1], with negatives, values past one and the corners mixed in
    function automatic logic [16:0] rand_param();
        logic [16:0] corners [4];
        corners = '{17'd0, 17'd1, 17'd32767, T_ONE};
        case ($urandom_range(0, 19))
            0, 1, 2: return {1'b1, 16'($urandom())};
            3, 4, 5: return 17'($urandom_range(32769, 65535));
            6:       return corners[$urandom_range(0, 3)];
            default: return 17'($urandom_range(0, 32768));
        endcase
    endfunction

    // Hold until every predicted result has been delivered
    task automatic wait_drained();
        do @(posedge aclk); while (pending != 0);
    endtask

    // Drained, then let the pipeline latency pass before touching registers
    task automatic wait_idle();
        wait_drained();
        repeat (8) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; junk in the upper bits must be ignored
    task automatic apb_write(pt_addr_t addr, logic [47:0] pt);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom()), pt};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_curve(logic [47:0] p0, logic [47:0] p1, logic [47:0] p2,
                              logic [47:0] p3);
        wait_idle();
        apb_write(ADDR_START, p0);
        apb_write(ADDR_START_HANDLE, p1);
        apb_write(ADDR_END_HANDLE, p2);
        apb_write(ADDR_END, p3);
    endtask

    // Drive one parameter transaction, optionally after a short gap
    task automatic send_param(logic [16:0] t);
        if (!quiet && send_bursts && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, t};
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        logic [16:0] corners [12];
        logic [16:0] sat_ts [5];
        int          style;

        // 0, smallest step, half, just under one, one, just past one, largest
        // positive, -1, most negative, quarter, three quarters, alternating bits
        corners = '{17'd0, 17'd1, 17'd16384, 17'd32767, T_ONE, 17'd32769,
                    17'h0FFFF, 17'h1FFFF, 17'h10000, 17'd8192, 17'd24576, 17'h0AAAA};
        sat_ts  = '{17'd0, 17'd10923, 17'd16384, 17'd21845, T_ONE};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers still at reset: every answer is the origin
        send_param(17'd0);
        send_param(17'd16384);
        send_param(17'h0FFFF);
        s_tvalid <= 1'b0;

        // Directed curve with mixed signs and range extremes in the points
        load_curve(pack_pt(16'h0100, 16'hFE00, 16'h7FFF),
                   pack_pt(16'h8000, 16'h0400, 16'h0000),
                   pack_pt(16'h0C00, 16'hFFFF, 16'h8000),
                   pack_pt(16'h7FFF, 16'h0300, 16'hF000));
        foreach (corners[i])
            send_param(corners[i]);
        s_tvalid <= 1'b0;

        // All points at the top of the range: rounded weights summing past one
        // must clamp instead of wrapping
        load_curve({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        foreach (sat_ts[i])
            send_param(sat_ts[i]);
        s_tvalid <= 1'b0;

        // Same at the bottom of the range
        load_curve({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        foreach (sat_ts[i])
            send_param(sat_ts[i]);
        s_tvalid <= 1'b0;

        // Random curves, cycling through value styles
        for (int ph = 0; ph < PHASES; ph++) begin
            style = ph % 3;
            load_curve(rand_point(style), rand_point(style), rand_point(style),
                       rand_point(style));
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == PHASES - 1 && n == 70)
                    quiet = 1'b1;
                if (n % 40 == 0)
                    send_bursts = $urandom_range(0, 2) != 0;
                if (ph == 1 && n == 110) begin
                    // hold the sender off until the pipeline has fully drained
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_param(rand_param());
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
